// ===== hw/rtl/assert_macros.svh =====
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/sjli_pkg.sv =====
// Package: widths, codes and types of the synchronized joint interpolator.
`default_nettype none

package sjli_pkg;

  localparam int JOINT_COUNT = 3;
  localparam int POS_W       = 16;
  localparam int STEP_W      = 16;
  localparam int SPR_W       = 16;
  localparam int DB_W        = 12;
  localparam int FRAC_SHIFT  = 20;                 // Q4.12 times Q8.8
  localparam int PROD_W      = POS_W + STEP_W;     // also covers POS_W + SPR_W
  localparam int DIV_CNT_W   = $clog2(PROD_W);
  localparam int IN_DATA_W   = ((JOINT_COUNT * POS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((JOINT_COUNT * POS_W + STEP_W + 7) / 8) * 8;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [SPR_W-1:0] SPR_RESET = SPR_W'(16000);
  localparam logic [DB_W-1:0]  DB_RESET  = DB_W'(4);
  localparam logic [STEP_W-1:0] STEP_MAX = '1;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic [POS_W-1:0]        mag_t;
  typedef logic [STEP_W-1:0]       step_t;
  typedef logic [PROD_W-1:0]       prod_t;

  typedef enum logic [1:0] {
    FUNC_FEEDBACK = 2'd0,
    FUNC_MOVE     = 2'd1,
    FUNC_TICK     = 2'd2,
    FUNC_UNUSED   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    STATUS_NOTHING   = 3'd0,
    STATUS_AT_TARGET = 3'd1,
    STATUS_STARTED   = 3'd2,
    STATUS_STEP      = 3'd3,
    STATUS_BUSY      = 3'd4,
    STATUS_IDLE      = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAX,
    ST_MUL,
    ST_STEPS,
    ST_DLOAD,
    ST_DIV,
    ST_OUT
  } state_t;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_STEPS_PER_RAD = 1'b0,
    REG_DEADBAND      = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic load_meas;
    logic latch_move;
    logic load_div;
    logic div_step;
  } lane_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/synchronized_joint_linear_interpolator_core.sv =====
// Top level: stream ports, APB registers, sequencer, lanes, merge and output register.
//
// Three-joint synchronized linear trajectory generator. Each input word is
// handled alone: a feedback or unused word, a busy answer and an idle-tick
// answer go straight to output; a move request passes lane latch, max over
// lanes, scaling multiply, step count and output; a step tick passes the
// one-bit-per-cycle restoring divider in each joint lane, then output. The
// result sits in an output register, so the next word is taken as soon as
// the sequencer is back to idle, even while m_tready is low; a result waits
// in the output state until that register is free or being read.
`default_nettype none
`include "assert_macros.svh"

module synchronized_joint_linear_interpolator_core
  import sjli_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // stream in
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // joint0_value, joint1_value, joint2_value
  input  wire logic [1:0]            s_tuser,   // func
  // stream out
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // joint0..2_command, step_number
  output logic [2:0]                 m_tuser,   // status
  output logic                       m_tlast,   // final_step
  // APB
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  logic [SPR_W-1:0] steps_per_radian;
  logic [DB_W-1:0]  deadband;

  state_t         state, state_next;
  status_t        status, status_next;
  step_t          step_count, step_count_next;
  step_t          cur_step, cur_step_next;
  logic           moving, moving_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;

  logic           out_valid;
  status_t        out_status;
  pos_t           out_cmd [JOINT_COUNT];
  step_t          out_step;
  logic           out_final;

  lane_ctrl_t     lane_ctrl;
  logic           en_max, en_mul, out_load, is_final;
  mag_t           lane_mag [JOINT_COUNT];
  pos_t           lane_cmd [JOINT_COUNT];
  prod_t          prod;
  logic           below;
  prod_t          steps_wide;
  func_t          func;
  reg_idx_t       reg_idx;
  logic           cfg_wr;
  logic [JOINT_COUNT*POS_W-1:0] cmd_flat;

  // ---------------- APB ----------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_radian <= SPR_RESET;
      deadband         <= DB_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_STEPS_PER_RAD: steps_per_radian <= pwdata[SPR_W-1:0];
        REG_DEADBAND:      deadband         <= pwdata[DB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_STEPS_PER_RAD: prdata = APB_DATA_W'(steps_per_radian);
      REG_DEADBAND:      prdata = APB_DATA_W'(deadband);
      default:           prdata = '0;
    endcase
  end

  // ---------------- lanes and merge ----------------
  genvar g;
  generate
    for (g = 0; g < JOINT_COUNT; g++) begin : g_lane
      sjli_lane u_lane (
        .clk   (clk),
        .rst   (rst),
        .ctrl  (lane_ctrl),
        .value (pos_t'(s_tdata[g*POS_W +: POS_W])),
        .step  (cur_step),
        .total (step_count),
        .mag   (lane_mag[g]),
        .cmd   (lane_cmd[g])
      );
    end
  endgenerate

  sjli_merge u_merge (
    .clk              (clk),
    .mag              (lane_mag),
    .en_max           (en_max),
    .en_mul           (en_mul),
    .steps_per_radian (steps_per_radian),
    .deadband         (deadband),
    .prod             (prod),
    .below            (below)
  );

  // ---------------- sequencer ----------------
  assign func       = func_t'(s_tuser);
  assign steps_wide = prod >> FRAC_SHIFT;
  assign is_final   = (status == STATUS_STEP) && (cur_step >= step_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      status     <= STATUS_NOTHING;
      step_count <= '0;
      cur_step   <= '0;
      moving     <= 1'b0;
      div_cnt    <= '0;
    end else begin
      state      <= state_next;
      status     <= status_next;
      step_count <= step_count_next;
      cur_step   <= cur_step_next;
      moving     <= moving_next;
      div_cnt    <= div_cnt_next;
    end
  end

  always_comb begin
    state_next      = state;
    status_next     = status;
    step_count_next = step_count;
    cur_step_next   = cur_step;
    moving_next     = moving;
    div_cnt_next    = div_cnt;
    lane_ctrl       = '0;
    en_max          = 1'b0;
    en_mul          = 1'b0;
    out_load        = 1'b0;
    s_tready        = 1'b0;

    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next  = ST_OUT;
          status_next = STATUS_NOTHING;
          case (func)
            FUNC_FEEDBACK: lane_ctrl.load_meas = 1'b1;
            FUNC_MOVE: begin
              if (moving) begin
                status_next = STATUS_BUSY;
              end else begin
                lane_ctrl.latch_move = 1'b1;
                state_next           = ST_MAX;
              end
            end
            FUNC_TICK: begin
              if (moving && step_count != '0) begin
                cur_step_next = STEP_W'(cur_step + 1'b1);
                status_next   = STATUS_STEP;
                state_next    = ST_DLOAD;
              end else begin
                moving_next = 1'b0;
                status_next = STATUS_IDLE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MAX: begin
        en_max     = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        en_mul     = 1'b1;
        state_next = ST_STEPS;
      end
      ST_STEPS: begin
        state_next = ST_OUT;
        if (below) begin
          status_next = STATUS_AT_TARGET;
        end else begin
          if (steps_wide == '0) begin
            step_count_next = STEP_W'(1);
          end else if (steps_wide > prod_t'(STEP_MAX)) begin
            step_count_next = STEP_MAX;
          end else begin
            step_count_next = steps_wide[STEP_W-1:0];
          end
          cur_step_next = '0;
          moving_next   = 1'b1;
          status_next   = STATUS_STARTED;
        end
      end
      ST_DLOAD: begin
        lane_ctrl.load_div = 1'b1;
        div_cnt_next       = '0;
        state_next         = ST_DIV;
      end
      ST_DIV: begin
        lane_ctrl.div_step = 1'b1;
        div_cnt_next       = DIV_CNT_W'(div_cnt + 1'b1);
        if (div_cnt == DIV_CNT_W'(PROD_W - 1)) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
          if (is_final) begin
            moving_next = 1'b0;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= status;
      out_final  <= is_final;
      out_step   <= (status == STATUS_STEP) ? cur_step : '0;
      for (int j = 0; j < JOINT_COUNT; j++) begin
        out_cmd[j] <= (status == STATUS_STEP) ? lane_cmd[j] : '0;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < JOINT_COUNT; j++) begin
      cmd_flat[j*POS_W +: POS_W] = out_cmd[j];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_DATA_W'({out_step, cmd_flat});
  assign m_tuser  = out_status;
  assign m_tlast  = out_final;

  // ---------------- checks ----------------
  `ASSERT_CLK(a_moving_has_steps, moving |-> (step_count != '0), "moving with zero step count")
  `ASSERT_CLK(a_step_in_range, moving |-> (cur_step <= step_count), "step beyond total")
  `ASSERT_CLK(a_final_stops, (out_load && is_final) |=> !moving, "final step left move active")

endmodule

`default_nettype wire

// ===== hw/rtl/sjli_lane.sv =====
// One joint lane: position store, displacement and restoring step divider.
`default_nettype none

module sjli_lane
  import sjli_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire lane_ctrl_t ctrl,
  input  wire pos_t       value,
  input  wire step_t      step,
  input  wire step_t      total,
  output mag_t            mag,
  output pos_t            cmd
);

  pos_t              measured;
  pos_t              start;
  logic              neg;
  logic [STEP_W-1:0] rem;
  prod_t             dq;

  logic signed [POS_W:0] diff;
  logic [STEP_W:0]       rem_sh;
  logic [STEP_W:0]       rem_sub;
  logic                  ge;
  mag_t                  quo;
  logic [POS_W:0]        sum;

  assign diff    = {value[POS_W-1], value} - {measured[POS_W-1], measured};
  assign rem_sh  = {rem, dq[PROD_W-1]};
  assign rem_sub = rem_sh - {1'b0, total};
  assign ge      = rem_sh >= {1'b0, total};
  assign quo     = dq[POS_W-1:0];   // quotient never exceeds mag
  assign sum     = {start[POS_W-1], start} + (neg ? -{1'b0, quo} : {1'b0, quo});
  assign cmd     = pos_t'(sum[POS_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      measured <= '0;
      start    <= '0;
      neg      <= 1'b0;
      mag      <= '0;
    end else begin
      if (ctrl.load_meas) begin
        measured <= value;
      end
      if (ctrl.latch_move) begin
        start <= measured;
        neg   <= diff[POS_W];
        mag   <= diff[POS_W] ? mag_t'(-diff) : mag_t'(diff);
      end
    end
  end

  // one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (ctrl.load_div) begin
      rem <= '0;
      dq  <= prod_t'(mag) * prod_t'(step);
    end else if (ctrl.div_step) begin
      rem <= ge ? rem_sub[STEP_W-1:0] : rem_sh[STEP_W-1:0];
      dq  <= {dq[PROD_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sjli_merge.sv =====
// Merge stage: largest lane displacement, deadband test and step scaling product.
`default_nettype none

module sjli_merge
  import sjli_pkg::*;
(
  input  wire logic             clk,
  input  wire mag_t             mag [JOINT_COUNT],
  input  wire logic             en_max,
  input  wire logic             en_mul,
  input  wire logic [SPR_W-1:0] steps_per_radian,
  input  wire logic [DB_W-1:0]  deadband,
  output prod_t                 prod,
  output logic                  below
);

  mag_t maxd;
  mag_t max_c;

  always_comb begin
    max_c = '0;
    for (int j = 0; j < JOINT_COUNT; j++) begin
      if (mag[j] > max_c) begin
        max_c = mag[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_max) begin
      maxd <= max_c;
    end
    if (en_mul) begin
      prod  <= prod_t'(maxd) * prod_t'(steps_per_radian);
      below <= prod_t'(maxd) < prod_t'(deadband);
    end
  end

endmodule

`default_nettype wire
